// File: rtl/pce_pkg.sv
// Shared types and constants for the parametric CRC engine.
// Holds register indexes, op codes, reset values and the control struct.
// No dependencies.
package pce_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int FIELD_W     = 32;
  localparam int WIDTH_W     = 6;
  localparam int NBYTES_W    = 3;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CRC_WIDTH     = 3'd0,
    REG_POLYNOMIAL    = 3'd1,
    REG_INITIAL_VALUE = 3'd2,
    REG_REFLECT_IN    = 3'd3,
    REG_REFLECT_OUT   = 3'd4,
    REG_XOR_OUT       = 3'd5
  } cfg_reg_t;

  // Item op codes
  typedef enum logic {
    OP_RESTART = 1'b0,
    OP_FEED    = 1'b1
  } op_t;

  localparam logic [WIDTH_W-1:0] RESET_CRC_WIDTH     = 6'd32;
  localparam logic [FIELD_W-1:0] RESET_POLYNOMIAL    = 32'h04C1_1DB7;
  localparam logic [FIELD_W-1:0] RESET_INITIAL_VALUE = 32'hFFFF_FFFF;
  localparam logic               RESET_REFLECT_IN    = 1'b1;
  localparam logic               RESET_REFLECT_OUT   = 1'b1;
  localparam logic [FIELD_W-1:0] RESET_XOR_OUT       = 32'hFFFF_FFFF;
  localparam logic [WIDTH_W-1:0] MIN_CRC_WIDTH       = 6'd8;

  // Derived control shared by the update and residue stages
  typedef struct packed {
    logic [WIDTH_W-1:0]  align_sh;    // shift that moves a value to the top of the word
    logic [NBYTES_W-1:0] nbytes;      // whole checksum bytes fed for the residue
    logic                reflect_in;
    logic                reflect_out;
  } crc_ctl_t;

endpackage

// File: rtl/pce_cfg.sv
// Configuration registers of the CRC engine and the values derived from them.
// Clamps the width and left-aligns the polynomial. Depends on pce_pkg.
module pce_cfg import pce_pkg::*; #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output crc_ctl_t               ctl,
  output logic [MAX_WIDTH-1:0]   poly_al,
  output logic [MAX_WIDTH-1:0]   init_m,
  output logic [MAX_WIDTH-1:0]   xor_m
);

  localparam int WB = WIDTH_W + 1;
  localparam logic [WB-1:0] MAX_W = WB'(MAX_WIDTH);

  logic [WIDTH_W-1:0] crc_width;
  logic [FIELD_W-1:0] polynomial;
  logic [FIELD_W-1:0] initial_value;
  logic               reflect_in;
  logic               reflect_out;
  logic [FIELD_W-1:0] xor_out;

  logic [WIDTH_W-1:0]   eff_width;
  logic [WB-1:0]        sh_wide;
  logic [MAX_WIDTH-1:0] mask;

  // Write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_width     <= RESET_CRC_WIDTH;
      polynomial    <= RESET_POLYNOMIAL;
      initial_value <= RESET_INITIAL_VALUE;
      reflect_in    <= RESET_REFLECT_IN;
      reflect_out   <= RESET_REFLECT_OUT;
      xor_out       <= RESET_XOR_OUT;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CRC_WIDTH:     crc_width     <= cfg_data[WIDTH_W-1:0];
        REG_POLYNOMIAL:    polynomial    <= cfg_data;
        REG_INITIAL_VALUE: initial_value <= cfg_data;
        REG_REFLECT_IN:    reflect_in    <= cfg_data[0];
        REG_REFLECT_OUT:   reflect_out   <= cfg_data[0];
        REG_XOR_OUT:       xor_out       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the width into the supported range
  always_comb begin
    if (crc_width < MIN_CRC_WIDTH) begin
      eff_width = MIN_CRC_WIDTH;
    end else if ({1'b0, crc_width} > MAX_W) begin
      eff_width = MAX_W[WIDTH_W-1:0];
    end else begin
      eff_width = crc_width;
    end
  end

  // Derive alignment, byte count and masked operands
  always_comb begin
    sh_wide         = MAX_W - {1'b0, eff_width};
    ctl.align_sh    = sh_wide[WIDTH_W-1:0];
    ctl.nbytes      = eff_width[WIDTH_W-1:3];
    ctl.reflect_in  = reflect_in;
    ctl.reflect_out = reflect_out;
    mask            = {MAX_WIDTH{1'b1}} >> ctl.align_sh;
    poly_al         = MAX_WIDTH'(polynomial) << ctl.align_sh;
    init_m          = MAX_WIDTH'(initial_value) & mask;
    xor_m           = MAX_WIDTH'(xor_out) & mask;
  end

endmodule

// File: rtl/pce_byte_feed.sv
// One byte of the MSB-first CRC update on a left-aligned register.
// Eight conditional shift-and-XOR steps against the aligned polynomial. Depends on pce_pkg.
module pce_byte_feed import pce_pkg::*; #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                 reflect,
  input  logic [MAX_WIDTH-1:0] crc_in,
  input  logic [7:0]           byte_in,
  input  logic [MAX_WIDTH-1:0] poly_al,
  output logic [MAX_WIDTH-1:0] crc_out
);

  logic [7:0]           byte_rev;
  logic [7:0]           byte_use;
  logic [7:0]           idx;
  logic [MAX_WIDTH-1:0] rem;

  assign byte_rev = {<<{byte_in}};
  assign byte_use = reflect ? byte_rev : byte_in;

  // Divide the top byte by the polynomial, then fold in the shifted register
  always_comb begin
    idx = byte_use ^ crc_in[MAX_WIDTH-1 -: 8];
    rem = MAX_WIDTH'(idx) << (MAX_WIDTH - 8);
    for (int k = 0; k < 8; k++) begin
      if (rem[MAX_WIDTH-1]) begin
        rem = (rem << 1) ^ poly_al;
      end else begin
        rem = rem << 1;
      end
    end
    crc_out = rem ^ (crc_in << 8);
  end

endmodule

// File: rtl/pce_state.sv
// Update stage: the CRC register memory and its read-modify-write.
// Forwards the value being written into the read register. Depends on pce_pkg, pce_byte_feed.
module pce_state import pce_pkg::*; #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  crc_ctl_t             ctl,
  input  logic [MAX_WIDTH-1:0] poly_al,
  input  logic [MAX_WIDTH-1:0] init_m,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [7:0]           data_byte,
  input  logic                 dn_ready,
  output logic                 raw_valid,
  output logic [MAX_WIDTH-1:0] raw_next
);

  logic [MAX_WIDTH-1:0] crc_mem [1];
  logic                 mem_valid;

  logic                 s1_valid;
  logic                 s1_op;
  logic [7:0]           s1_byte;
  logic [MAX_WIDTH-1:0] s1_cur;

  logic                 accept;
  logic                 wr_en;
  logic [MAX_WIDTH-1:0] cur_al;
  logic [MAX_WIDTH-1:0] fed_al;

  assign in_stall  = s1_valid && !dn_ready;
  assign accept    = in_valid && !in_stall;
  assign wr_en     = s1_valid && dn_ready;
  assign raw_valid = s1_valid;

  // Align the current register to the top of the word and feed the byte
  assign cur_al = s1_cur << ctl.align_sh;

  pce_byte_feed #(.MAX_WIDTH(MAX_WIDTH)) u_feed (
    .reflect (ctl.reflect_in),
    .crc_in  (cur_al),
    .byte_in (s1_byte),
    .poly_al (poly_al),
    .crc_out (fed_al)
  );

  assign raw_next = (s1_op == OP_FEED) ? (fed_al >> ctl.align_sh) : init_m;

  // Write back the new register; read with write-first forwarding
  always_ff @(posedge clk) begin
    if (wr_en) begin
      crc_mem[0] <= raw_next;
    end
    if (accept) begin
      s1_op   <= op;
      s1_byte <= data_byte;
      if (wr_en) begin
        s1_cur <= raw_next;
      end else if (mem_valid) begin
        s1_cur <= crc_mem[0];
      end else begin
        s1_cur <= MAX_WIDTH'(RESET_INITIAL_VALUE);
      end
    end
  end

  // Stage occupancy and memory validity
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      mem_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (wr_en) begin
        mem_valid <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/pce_residue.sv
// Finish and residue pipeline: checksum, one checksum byte per stage, output register.
// Works on a copy of the register; the stored register is untouched.
// Depends on pce_pkg, pce_byte_feed.
module pce_residue import pce_pkg::*; #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  crc_ctl_t             ctl,
  input  logic [MAX_WIDTH-1:0] poly_al,
  input  logic [MAX_WIDTH-1:0] xor_m,
  input  logic                 raw_valid,
  input  logic [MAX_WIDTH-1:0] raw_in,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FIELD_W-1:0]   raw_value,
  output logic [FIELD_W-1:0]   checksum,
  output logic [FIELD_W-1:0]   residue
);

  localparam int NB = MAX_WIDTH / 8;
  localparam int KW = (NB > 1) ? $clog2(NB) : 1;

  // Finish stage
  logic                 f_valid;
  logic [MAX_WIDTH-1:0] f_raw;
  logic [MAX_WIDTH-1:0] f_al;
  logic [MAX_WIDTH-1:0] f_rev;
  logic [MAX_WIDTH-1:0] f_sum;

  // Byte stages
  logic                 b_valid [NB];
  logic                 b_take  [NB];
  logic [MAX_WIDTH-1:0] b_raw   [NB];
  logic [MAX_WIDTH-1:0] b_sum   [NB];
  logic [MAX_WIDTH-1:0] b_copy  [NB];
  logic [MAX_WIDTH-1:0] b_next  [NB];

  // Output stage
  logic                 o_take;
  logic [MAX_WIDTH-1:0] last_rev;
  logic [MAX_WIDTH-1:0] res;

  assign o_take = !out_valid || !out_stall;
  assign ready  = !f_valid || b_take[0];

  // Reflect over the width via the aligned form, then apply the final XOR
  assign f_al  = f_raw << ctl.align_sh;
  assign f_rev = {<<{f_al}};
  assign f_sum = (ctl.reflect_out ? f_rev : f_raw) ^ xor_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (ready) begin
      f_valid <= raw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && raw_valid) begin
      f_raw <= raw_in;
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_byte
    localparam logic [NBYTES_W-1:0] J = NBYTES_W'(j);

    logic                 active;
    logic [NBYTES_W-1:0]  pos;
    logic [NB-1:0][7:0]   sum_bytes;
    logic [7:0]           sel;
    logic [MAX_WIDTH-1:0] fed;
    logic                 prev_valid;
    logic [MAX_WIDTH-1:0] prev_raw;
    logic [MAX_WIDTH-1:0] prev_sum;
    logic [MAX_WIDTH-1:0] prev_copy;

    // Pick the checksum byte for this position
    assign active    = J < ctl.nbytes;
    assign pos       = ctl.reflect_out ? J : (ctl.nbytes - NBYTES_W'(1) - J);
    assign sum_bytes = b_sum[j][NB*8-1:0];
    assign sel       = sum_bytes[pos[KW-1:0]];

    pce_byte_feed #(.MAX_WIDTH(MAX_WIDTH)) u_feed (
      .reflect (ctl.reflect_in),
      .crc_in  (b_copy[j]),
      .byte_in (sel),
      .poly_al (poly_al),
      .crc_out (fed)
    );

    assign b_next[j] = active ? fed : b_copy[j];

    if (j == NB - 1) begin : g_last
      assign b_take[j] = !b_valid[j] || o_take;
    end else begin : g_mid
      assign b_take[j] = !b_valid[j] || b_take[j+1];
    end

    if (j == 0) begin : g_first
      assign prev_valid = f_valid;
      assign prev_raw   = f_raw;
      assign prev_sum   = f_sum;
      assign prev_copy  = f_al;
    end else begin : g_chain
      assign prev_valid = b_valid[j-1];
      assign prev_raw   = b_raw[j-1];
      assign prev_sum   = b_sum[j-1];
      assign prev_copy  = b_next[j-1];
    end

    // Advance the stage when it is empty or its successor moves
    always_ff @(posedge clk) begin
      if (rst) begin
        b_valid[j] <= 1'b0;
      end else if (b_take[j]) begin
        b_valid[j] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (b_take[j] && prev_valid) begin
        b_raw[j]  <= prev_raw;
        b_sum[j]  <= prev_sum;
        b_copy[j] <= prev_copy;
      end
    end
  end

  // Residue back to the low end, reflected over the width when selected
  assign last_rev = {<<{b_next[NB-1]}};
  assign res      = ctl.reflect_out ? last_rev : (b_next[NB-1] >> ctl.align_sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_take) begin
      out_valid <= b_valid[NB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (o_take && b_valid[NB-1]) begin
      raw_value <= FIELD_W'(b_raw[NB-1]);
      checksum  <= FIELD_W'(b_sum[NB-1]);
      residue   <= FIELD_W'(res);
    end
  end

endmodule

// File: rtl/parametric_crc_engine.sv
// Channel | Dir | Handshake              | Payload
// cfg     | in  | cfg_write              | cfg_index, cfg_data
// in      | in  | in_valid / in_stall    | op, data_byte
// out     | out | out_valid / out_stall  | raw_value, checksum, residue
//
// One item per cycle sustained unless out_stall backs up into in_stall; a result
// passes the update, finish, byte and output stages in turn.
// The rate is set by the read-modify-write of the CRC register memory in the
// update stage, with the written value forwarded into the next read.
// rst (synchronous) empties the pipeline and restores the register defaults;
// the CRC register reads as 0xFFFFFFFF until first written.
// out_stall holds the output register; empty stages still fill behind it, and
// in_stall rises only when the update stage is full and cannot move.
//
// Top level of the parametric CRC engine. Depends on pce_pkg, pce_cfg, pce_state,
// pce_residue and pce_byte_feed.
module parametric_crc_engine import pce_pkg::*; #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   op,
  input  logic [7:0]             data_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [FIELD_W-1:0]     raw_value,
  output logic [FIELD_W-1:0]     checksum,
  output logic [FIELD_W-1:0]     residue
);

  crc_ctl_t             ctl;
  logic [MAX_WIDTH-1:0] poly_al;
  logic [MAX_WIDTH-1:0] init_m;
  logic [MAX_WIDTH-1:0] xor_m;
  logic                 raw_valid;
  logic [MAX_WIDTH-1:0] raw_next;
  logic                 dn_ready;

  pce_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .poly_al   (poly_al),
    .init_m    (init_m),
    .xor_m     (xor_m)
  );

  pce_state #(.MAX_WIDTH(MAX_WIDTH)) u_state (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .poly_al   (poly_al),
    .init_m    (init_m),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .data_byte (data_byte),
    .dn_ready  (dn_ready),
    .raw_valid (raw_valid),
    .raw_next  (raw_next)
  );

  pce_residue #(.MAX_WIDTH(MAX_WIDTH)) u_residue (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .poly_al   (poly_al),
    .xor_m     (xor_m),
    .raw_valid (raw_valid),
    .raw_in    (raw_next),
    .ready     (dn_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .raw_value (raw_value),
    .checksum  (checksum),
    .residue   (residue)
  );

  // Input is held back only while the update stage holds an item
  a_stall_needs_item: assert property (@(posedge clk) in_stall |-> raw_valid)
    else $error("in_stall raised with the update stage empty");

  // An accepted item lands in the update stage
  a_accept_fills_update: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> raw_valid)
    else $error("accepted item missing from the update stage");

  // Reset empties the output register
  a_reset_clears_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

// File: dv/tb_parametric_crc_engine.sv
// Self-checking testbench for parametric_crc_engine: random and directed items
// across several CRC settings, checked against an in-bench CRC predictor.
// Depends on pce_pkg and the parametric_crc_engine RTL only.
module tb_parametric_crc_engine;
  import pce_pkg::*;

  localparam int MAX_W         = 32;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 600000;
  localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_HI = 3'd7;

  typedef struct {
    op_t         op;
    logic [7:0]  data;
    int unsigned gap;
  } crc_item_t;

  typedef struct {
    logic [FIELD_W-1:0] raw;
    logic [FIELD_W-1:0] sum;
    logic [FIELD_W-1:0] res;
  } crc_result_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic                   op        = OP_RESTART;
  logic [7:0]             data_byte = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [FIELD_W-1:0]     raw_value;
  logic [FIELD_W-1:0]     checksum;
  logic [FIELD_W-1:0]     residue;

  // Predictor copy of the settings and the CRC register
  logic [WIDTH_W-1:0] model_width  = RESET_CRC_WIDTH;
  logic [FIELD_W-1:0] model_poly   = RESET_POLYNOMIAL;
  logic [FIELD_W-1:0] model_init   = RESET_INITIAL_VALUE;
  logic               model_refin  = RESET_REFLECT_IN;
  logic               model_refout = RESET_REFLECT_OUT;
  logic [FIELD_W-1:0] model_xor    = RESET_XOR_OUT;
  logic [FIELD_W-1:0] crc_state    = 32'hFFFF_FFFF;

  crc_item_t   crc_items_pending[$];
  crc_result_t crc_results_due[$];
  crc_item_t   next_item;
  int unsigned items_queued = 0;
  int unsigned items_taken  = 0;
  int unsigned tx_wait      = 0;
  int unsigned out_hold     = 0;
  int unsigned draw;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  bit          tx_calm      = 1'b1;
  bit          rx_calm      = 1'b1;

  parametric_crc_engine #(.MAX_WIDTH(MAX_W)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .raw_value (raw_value),
    .checksum  (checksum),
    .residue   (residue)
  );

  always #5 clk = ~clk;

  // Clamp the width register to the range the block supports
  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(model_width);
    if (w < MIN_CRC_WIDTH) w = 32'(MIN_CRC_WIDTH);
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic logic [FIELD_W-1:0] width_mask(int unsigned w);
    logic [63:0] m;
    m = (64'd1 << w) - 64'd1;
    return m[FIELD_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] bit_reverse(logic [FIELD_W-1:0] v, int unsigned w);
    logic [FIELD_W-1:0] r;
    r = '0;
    for (int unsigned i = 0; i < w; i++) r[w-1-i] = v[i];
    return r;
  endfunction

  // MSB-first byte update: divide the top byte by the polynomial, fold in the shifted register
  function automatic logic [FIELD_W-1:0] crc_feed(logic [FIELD_W-1:0] r, logic [7:0] b,
                                                  int unsigned w);
    logic [FIELD_W-1:0] mask, msb, poly, rem, flipped;
    logic [7:0] idx, bb;
    mask = width_mask(w);
    msb  = 32'd1 << (w - 1);
    poly = model_poly & mask;
    flipped = bit_reverse({24'd0, b}, 8);
    bb = model_refin ? flipped[7:0] : b;
    r = r & mask;
    idx = bb ^ 8'(r >> (w - 8));
    rem = {24'd0, idx} << (w - 8);
    for (int k = 0; k < 8; k++) begin
      if ((rem & msb) != 0) rem = ((rem << 1) ^ poly) & mask;
      else rem = (rem << 1) & mask;
    end
    return (rem ^ (r << 8)) & mask;
  endfunction

  // Advance the register by one item and form raw value, checksum and residue
  function automatic crc_result_t next_crc_result(op_t o, logic [7:0] b);
    int unsigned w, nbytes, sh;
    logic [FIELD_W-1:0] mask, sum, shadow;
    crc_result_t r;
    w = eff_width();
    mask = width_mask(w);
    if (o == OP_RESTART) crc_state = model_init & mask;
    else crc_state = crc_feed(crc_state, b, w);
    crc_state = crc_state & mask;
    sum = model_refout ? bit_reverse(crc_state, w) : crc_state;
    sum = (sum ^ model_xor) & mask;
    // Feed the checksum bytes through a shadow copy; the real register stays put
    nbytes = w / 8;
    shadow = crc_state;
    for (int unsigned i = 0; i < nbytes; i++) begin
      sh = model_refout ? 8 * i : 8 * (nbytes - 1 - i);
      shadow = crc_feed(shadow, 8'(sum >> sh), w);
    end
    shadow = shadow & mask;
    r.raw = crc_state;
    r.sum = sum;
    r.res = model_refout ? bit_reverse(shadow, w) : shadow;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                 logic [FIELD_W-1:0] want);
    $display("MISMATCH %s: got %08h expected %08h at cycle %0d", what, got, want,
             cycle_count);
    fail_count++;
  endtask

  // Item driver: present queued items, hold while stalled, idle for each item's drawn gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      op        <= OP_RESTART;
      data_byte <= '0;
      tx_wait   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        crc_results_due.push_back(next_crc_result(op_t'(op), data_byte));
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_wait != 0) begin
          in_valid <= 1'b0;
          tx_wait  <= tx_wait - 1;
        end else if (crc_items_pending.size() != 0) begin
          next_item = crc_items_pending.pop_front();
          in_valid  <= 1'b1;
          op        <= next_item.op;
          data_byte <= next_item.data;
          tx_wait   <= next_item.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted result, then stall for a random hold unless rx_calm is set
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else if (out_valid && !out_stall) begin
      if (crc_results_due.size() == 0) begin
        report_mismatch("unexpected result raw_value", raw_value, '0);
      end else begin
        crc_result_t want;
        want = crc_results_due.pop_front();
        if (raw_value !== want.raw) report_mismatch("raw_value", raw_value, want.raw);
        if (checksum !== want.sum) report_mismatch("checksum", checksum, want.sum);
        if (residue !== want.res) report_mismatch("residue", residue, want.res);
      end
      draw = rx_calm ? 0 : $urandom_range(0, 15);
      out_hold  <= draw;
      out_stall <= (draw != 0);
    end else if (out_hold > 1) begin
      out_hold <= out_hold - 1;
    end else begin
      out_hold  <= 0;
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_item(op_t o, logic [7:0] d);
    crc_item_t it;
    it.op   = o;
    it.data = d;
    it.gap  = tx_calm ? 0 : $urandom_range(0, 15);
    crc_items_pending.push_back(it);
    items_queued++;
  endtask

  // Mostly long byte runs with an occasional restart carrying a random, ignored byte
  task automatic random_items(int unsigned n, bit lead_restart);
    if (lead_restart) queue_item(OP_RESTART, 8'($urandom));
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) queue_item(OP_RESTART, 8'($urandom));
      else queue_item(OP_FEED, 8'($urandom));
    end
  endtask

  // Hold until every item is taken and every result checked, then let the pipe drain
  task automatic wait_idle();
    while (items_taken != items_queued || crc_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_CRC_WIDTH:     model_width  = val[WIDTH_W-1:0];
      REG_POLYNOMIAL:    model_poly   = val;
      REG_INITIAL_VALUE: model_init   = val;
      REG_REFLECT_IN:    model_refin  = val[0];
      REG_REFLECT_OUT:   model_refout = val[0];
      REG_XOR_OUT:       model_xor    = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic program_crc(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] poly,
                             logic [CFG_DATA_W-1:0] init, logic [CFG_DATA_W-1:0] ri,
                             logic [CFG_DATA_W-1:0] ro, logic [CFG_DATA_W-1:0] xo);
    write_reg(REG_CRC_WIDTH, w);
    write_reg(REG_POLYNOMIAL, poly);
    write_reg(REG_INITIAL_VALUE, init);
    write_reg(REG_REFLECT_IN, ri);
    write_reg(REG_REFLECT_OUT, ro);
    write_reg(REG_XOR_OUT, xo);
    end_writes();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings (reflected CRC-32): restart, check string, byte extremes
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    queue_item(OP_RESTART, 8'hFF);
    for (int c = 8'h31; c <= 8'h39; c++) queue_item(OP_FEED, 8'(c));
    queue_item(OP_FEED, 8'h00);
    queue_item(OP_FEED, 8'hFF);
    queue_item(OP_FEED, 8'h80);
    queue_item(OP_FEED, 8'h01);
    queue_item(OP_RESTART, 8'h00);
    queue_item(OP_FEED, 8'h55);
    queue_item(OP_FEED, 8'hAA);
    random_items(60, 1'b0);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    random_items(60, 1'b0);
    wait_idle();

    // Narrowest plain CRC-8, nothing reflected
    program_crc(32'd8, 32'h07, 32'h0, 32'd0, 32'd0, 32'h0);
    random_items(80, 1'b1);
    wait_idle();

    // 16-bit non-reflected, back to back
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    program_crc(32'd16, 32'h1021, 32'hFFFF, 32'd0, 32'd0, 32'h0);
    random_items(80, 1'b1);
    wait_idle();

    // Width below range, all-ones operands masked down
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    program_crc(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'hA5A5_A5A5);
    queue_item(OP_RESTART, 8'h5A);
    queue_item(OP_FEED, 8'h00);
    queue_item(OP_FEED, 8'hFF);
    random_items(80, 1'b0);
    wait_idle();

    // Width above range, zero polynomial and initial value
    rx_calm = 1'b1;
    program_crc(32'd63, 32'h0, 32'h0, 32'd0, 32'd1, 32'h0);
    random_items(80, 1'b1);
    wait_idle();

    // Width not a multiple of eight, output reflected
    tx_calm = 1'b1;
    rx_calm = 1'b0;
    program_crc(32'd12, 32'h80F, 32'h0, 32'd0, 32'd1, 32'hFFF);
    random_items(80, 1'b1);
    wait_idle();

    // Change width mid-stream without a restart; also poke the spare indexes
    tx_calm = 1'b0;
    write_reg(SPARE_INDEX_LO, $urandom);
    write_reg(SPARE_INDEX_HI, $urandom);
    write_reg(REG_CRC_WIDTH, 32'd24);
    end_writes();
    random_items(80, 1'b0);
    wait_idle();

    // Fully random settings, idling mixed per phase
    for (int p = 0; p < 6; p++) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      program_crc($urandom_range(0, 63), $urandom, $urandom, $urandom_range(0, 1),
                  $urandom_range(0, 1), $urandom);
      random_items(75, 1'($urandom_range(0, 1)));
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
